// File: design/iirf_pkg.sv
// Shared types and constants for the fourth-order IIR filter core.
// Word structs, coefficient set, register index codes, accumulator sizing.
// No dependencies.
`default_nettype none

package iirf_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int COEF_WIDTH   = 32;
	localparam int OUTPUT_WIDTH = 32;
	localparam int FRAC_BITS    = COEF_WIDTH - 4;

	// each coefficient sits in the low bits of a 32-bit slot
	localparam int SLOT_WIDTH   = 32;
	localparam int CFG_WIDTH    = 2 * SLOT_WIDTH;
	localparam int CFG_IDX_W    = 3;

	// exact sum of nine products with headroom
	localparam int HIST_MAX_W   = (SAMPLE_WIDTH > OUTPUT_WIDTH) ? SAMPLE_WIDTH : OUTPUT_WIDTH;
	localparam int ACC_WIDTH    = COEF_WIDTH + HIST_MAX_W + 4;
	localparam int RND_WIDTH    = ACC_WIDTH - FRAC_BITS;
	localparam int FWD_P_WIDTH  = COEF_WIDTH + SAMPLE_WIDTH;
	localparam int FB_P_WIDTH   = COEF_WIDTH + OUTPUT_WIDTH;

	localparam logic [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1) << (FRAC_BITS - 1);
	localparam logic [OUTPUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUTPUT_WIDTH-1){1'b1}}};
	localparam logic [OUTPUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUTPUT_WIDTH-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FEEDBACK_ONE = 3'd0,
		REG_FEEDBACK_TWO = 3'd1,
		REG_FORWARD_ONE  = 3'd2,
		REG_FORWARD_TWO  = 3'd3,
		REG_FORWARD_LAST = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample_in;
		logic                           pulse_start;
	} in_word_t;

	typedef struct packed {
		logic signed [OUTPUT_WIDTH-1:0] sample_out;
		logic                           saturated;
	} out_word_t;

	typedef struct packed {
		logic [3:0][COEF_WIDTH-1:0] a;   // a1..a4
		logic [4:0][COEF_WIDTH-1:0] b;   // b0..b4
	} coef_set_t;

endpackage

`default_nettype wire

// File: design/iirf_coef_regs.sv
// Coefficient register bank: plain write port, five packed registers.
// Unpacks the slots into a coefficient set. Uses iirf_pkg.
`default_nettype none

module iirf_coef_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [iirf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [iirf_pkg::CFG_WIDTH-1:0]   cfg_data,
	output iirf_pkg::coef_set_t                   coefs
);

	logic [iirf_pkg::CFG_WIDTH-1:0]  fb_one_q;
	logic [iirf_pkg::CFG_WIDTH-1:0]  fb_two_q;
	logic [iirf_pkg::CFG_WIDTH-1:0]  fwd_one_q;
	logic [iirf_pkg::CFG_WIDTH-1:0]  fwd_two_q;
	logic [iirf_pkg::SLOT_WIDTH-1:0] fwd_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_one_q   <= '0;
			fb_two_q   <= '0;
			fwd_one_q  <= '0;
			fwd_two_q  <= '0;
			fwd_last_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (iirf_pkg::reg_index_t'(cfg_index))
				iirf_pkg::REG_FEEDBACK_ONE: fb_one_q   <= cfg_data;
				iirf_pkg::REG_FEEDBACK_TWO: fb_two_q   <= cfg_data;
				iirf_pkg::REG_FORWARD_ONE:  fwd_one_q  <= cfg_data;
				iirf_pkg::REG_FORWARD_TWO:  fwd_two_q  <= cfg_data;
				iirf_pkg::REG_FORWARD_LAST: fwd_last_q <= cfg_data[iirf_pkg::SLOT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	localparam int CW = iirf_pkg::COEF_WIDTH;
	localparam int SW = iirf_pkg::SLOT_WIDTH;

	always_comb begin
		coefs.a[0] = fb_one_q[CW-1:0];
		coefs.a[1] = fb_one_q[SW+CW-1:SW];
		coefs.a[2] = fb_two_q[CW-1:0];
		coefs.a[3] = fb_two_q[SW+CW-1:SW];
		coefs.b[0] = fwd_one_q[CW-1:0];
		coefs.b[1] = fwd_one_q[SW+CW-1:SW];
		coefs.b[2] = fwd_two_q[CW-1:0];
		coefs.b[3] = fwd_two_q[SW+CW-1:SW];
		coefs.b[4] = fwd_last_q[CW-1:0];
	end

endmodule

`default_nettype wire

// File: design/iirf_datapath.sv
// Single-pass filter arithmetic: nine products, exact sum, round, saturate.
// Purely combinational. Uses iirf_pkg.
`default_nettype none

module iirf_datapath (
	input  wire iirf_pkg::in_word_t                     word,
	input  wire iirf_pkg::coef_set_t                    coefs,
	input  wire logic signed [iirf_pkg::SAMPLE_WIDTH-1:0] x_hist [4],
	input  wire logic signed [iirf_pkg::OUTPUT_WIDTH-1:0] y_hist [4],
	output iirf_pkg::out_word_t                         result
);

	localparam int AW = iirf_pkg::ACC_WIDTH;
	localparam int OW = iirf_pkg::OUTPUT_WIDTH;
	localparam int RW = iirf_pkg::RND_WIDTH;

	logic signed [iirf_pkg::FWD_P_WIDTH-1:0] fwd_p [5];
	logic signed [iirf_pkg::FB_P_WIDTH-1:0]  fb_p  [4];
	logic signed [AW-1:0]                    acc;
	logic        [AW-1:0]                    acc_r;
	logic        [RW-1:0]                    rnd;
	logic        [RW-OW:0]                   upper;
	logic                                    sat;

	always_comb begin
		fwd_p[0] = $signed(coefs.b[0]) * word.sample_in;
		for (int i = 0; i < 4; i++) begin
			fwd_p[i+1] = $signed(coefs.b[i+1]) * x_hist[i];
			fb_p[i]    = $signed(coefs.a[i]) * y_hist[i];
			// a pulse start sees an all-zero history
			if (word.pulse_start) begin
				fwd_p[i+1] = '0;
				fb_p[i]    = '0;
			end
		end

		acc = AW'(fwd_p[0]);
		for (int i = 0; i < 4; i++) begin
			acc = acc + AW'(fwd_p[i+1]) - AW'(fb_p[i]);
		end

		acc_r = acc + iirf_pkg::ROUND_HALF;
		rnd   = acc_r[AW-1:iirf_pkg::FRAC_BITS];
		upper = rnd[RW-1:OW-1];
		sat   = !((&upper) || !(|upper));

		result.saturated = sat;
		if (sat) begin
			result.sample_out = rnd[RW-1] ? iirf_pkg::OUT_MIN : iirf_pkg::OUT_MAX;
		end else begin
			result.sample_out = rnd[OW-1:0];
		end
	end

endmodule

`default_nettype wire

// File: design/iirf_hist.sv
// Input and output history shift lines, four taps each, cleared by reset.
// A pulse start clears older taps as the new word shifts in. Uses iirf_pkg.
`default_nettype none

module iirf_hist (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      shift,
	input  wire logic                                      pulse_start,
	input  wire logic signed [iirf_pkg::SAMPLE_WIDTH-1:0]  x_new,
	input  wire logic signed [iirf_pkg::OUTPUT_WIDTH-1:0]  y_new,
	output logic signed [iirf_pkg::SAMPLE_WIDTH-1:0]       x_hist [4],
	output logic signed [iirf_pkg::OUTPUT_WIDTH-1:0]       y_hist [4]
);

	logic signed [iirf_pkg::SAMPLE_WIDTH-1:0] x_hist_q [4];
	logic signed [iirf_pkg::OUTPUT_WIDTH-1:0] y_hist_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				x_hist_q[i] <= '0;
				y_hist_q[i] <= '0;
			end
		end else if (shift) begin
			x_hist_q[0] <= x_new;
			y_hist_q[0] <= y_new;
			for (int i = 1; i < 4; i++) begin
				x_hist_q[i] <= pulse_start ? '0 : x_hist_q[i-1];
				y_hist_q[i] <= pulse_start ? '0 : y_hist_q[i-1];
			end
		end
	end

	assign x_hist = x_hist_q;
	assign y_hist = y_hist_q;

endmodule

`default_nettype wire

// File: design/iir_fourth_order_filter_core.sv
// Fourth-order direct form I IIR filter core.
// An accepted word is held in the input register and moves into the result register once that is free.
// Throughput: one word per cycle while the output is not stalled; the recursion closes through the
// combinational multiply-accumulate between the input register and the result register.
// Reset: arst_n clears coefficients, histories and valid flags asynchronously.
// Uses iirf_pkg, iirf_coef_regs, iirf_datapath, iirf_hist.
`default_nettype none

module iir_fourth_order_filter_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire iirf_pkg::in_word_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output iirf_pkg::out_word_t                 out_data,
	input  wire logic                           cfg_wr_en,
	input  wire logic [iirf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [iirf_pkg::CFG_WIDTH-1:0] cfg_data
);

	iirf_pkg::coef_set_t coefs;
	iirf_pkg::in_word_t  word_s1;
	logic                valid_s1;
	iirf_pkg::out_word_t result;
	iirf_pkg::out_word_t out_word_q;
	logic                out_valid_q;
	logic                advance;
	logic signed [iirf_pkg::SAMPLE_WIDTH-1:0] x_hist [4];
	logic signed [iirf_pkg::OUTPUT_WIDTH-1:0] y_hist [4];

	iirf_coef_regs u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coefs     (coefs)
	);

	// word in s1 moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_data;
		end
	end

	iirf_datapath u_dp (
		.word   (word_s1),
		.coefs  (coefs),
		.x_hist (x_hist),
		.y_hist (y_hist),
		.result (result)
	);

	iirf_hist u_hist (
		.clk         (clk),
		.arst_n      (arst_n),
		.shift       (advance),
		.pulse_start (word_s1.pulse_start),
		.x_new       (word_s1.sample_in),
		.y_new       (result.sample_out),
		.x_hist      (x_hist),
		.y_hist      (y_hist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked word");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced word did not reach result register");

	a_sat_clips: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_word_q.saturated) |->
		(out_word_q.sample_out == iirf_pkg::OUT_MAX || out_word_q.sample_out == iirf_pkg::OUT_MIN))
		else $error("saturated word not at a limit");

	a_pulse_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && word_s1.pulse_start) |=>
		(x_hist[1] == '0 && x_hist[2] == '0 && x_hist[3] == '0 &&
		 y_hist[1] == '0 && y_hist[2] == '0 && y_hist[3] == '0))
		else $error("pulse start left stale history");

endmodule

`default_nettype wire

// File: test/iir_fourth_order_filter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for iir_fourth_order_filter_core: directed, random and stall tests,
// every output word compared against an in-bench filter predictor. Depends on iirf_pkg.

module iir_fourth_order_filter_core_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;
	localparam logic [iirf_pkg::CFG_IDX_W-1:0] UNUSED_REG_INDEX = 3'd7;
	localparam logic [iirf_pkg::SLOT_WIDTH-1:0] COEF_ONE  = 32'h1000_0000;  // 1.0 in Q4.28
	localparam logic [iirf_pkg::SLOT_WIDTH-1:0] COEF_HALF = 32'h0800_0000;
	localparam logic [iirf_pkg::SLOT_WIDTH-1:0] COEF_MAX  = 32'h7FFF_FFFF;
	localparam logic [iirf_pkg::SLOT_WIDTH-1:0] COEF_MIN  = 32'h8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	iirf_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	iirf_pkg::out_word_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [iirf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [iirf_pkg::CFG_WIDTH-1:0] cfg_data = '0;

	// predictor state
	logic [iirf_pkg::CFG_WIDTH-1:0] cfg_shadow [5];
	logic signed [iirf_pkg::SAMPLE_WIDTH-1:0] x_hist [4];
	logic signed [iirf_pkg::OUTPUT_WIDTH-1:0] y_hist [4];
	iirf_pkg::out_word_t pending_outputs [$];

	bit calm = 1'b0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int words_sent = 0;
	int outputs_checked = 0;
	int saturated_seen = 0;
	int settings_used = 0;

	iir_fourth_order_filter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
				pending_outputs.size());
			$display("FAILURE");
			$finish;
		end
	end

	// receiver stall: random, calm, or a long hold counted here
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 25);
		end
	end

	// exact direct form I sum, round half up, saturate; saturated value is fed back
	function automatic iirf_pkg::out_word_t compute_filter_output(iirf_pkg::in_word_t w);
		logic signed [iirf_pkg::SLOT_WIDTH-1:0] a [4];
		logic signed [iirf_pkg::SLOT_WIDTH-1:0] b [5];
		logic signed [127:0] acc, cv, hv;
		logic signed [iirf_pkg::SAMPLE_WIDTH-1:0] xv;
		iirf_pkg::out_word_t r;
		a[0] = cfg_shadow[iirf_pkg::REG_FEEDBACK_ONE][31:0];
		a[1] = cfg_shadow[iirf_pkg::REG_FEEDBACK_ONE][63:32];
		a[2] = cfg_shadow[iirf_pkg::REG_FEEDBACK_TWO][31:0];
		a[3] = cfg_shadow[iirf_pkg::REG_FEEDBACK_TWO][63:32];
		b[0] = cfg_shadow[iirf_pkg::REG_FORWARD_ONE][31:0];
		b[1] = cfg_shadow[iirf_pkg::REG_FORWARD_ONE][63:32];
		b[2] = cfg_shadow[iirf_pkg::REG_FORWARD_TWO][31:0];
		b[3] = cfg_shadow[iirf_pkg::REG_FORWARD_TWO][63:32];
		b[4] = cfg_shadow[iirf_pkg::REG_FORWARD_LAST][31:0];
		if (w.pulse_start) begin
			for (int i = 0; i < 4; i++) begin
				x_hist[i] = '0;
				y_hist[i] = '0;
			end
		end
		acc = '0;
		for (int k = 0; k < 5; k++) begin
			xv = (k == 0) ? w.sample_in : x_hist[k-1];
			cv = b[k];
			hv = xv;
			acc = acc + cv * hv;
		end
		for (int k = 0; k < 4; k++) begin
			cv = a[k];
			hv = y_hist[k];
			acc = acc - cv * hv;
		end
		acc = acc + (128'sd1 <<< (iirf_pkg::FRAC_BITS - 1));
		acc = acc >>> iirf_pkg::FRAC_BITS;
		if (acc > $signed(iirf_pkg::OUT_MAX)) begin
			r.sample_out = iirf_pkg::OUT_MAX;
			r.saturated = 1'b1;
		end else if (acc < $signed(iirf_pkg::OUT_MIN)) begin
			r.sample_out = iirf_pkg::OUT_MIN;
			r.saturated = 1'b1;
		end else begin
			r.sample_out = acc[iirf_pkg::OUTPUT_WIDTH-1:0];
			r.saturated = 1'b0;
		end
		for (int i = 3; i > 0; i--) begin
			x_hist[i] = x_hist[i-1];
			y_hist[i] = y_hist[i-1];
		end
		x_hist[0] = w.sample_in;
		y_hist[0] = r.sample_out;
		return r;
	endfunction

	always @(posedge clk) begin
		iirf_pkg::out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outputs.size() == 0) begin
				$error("output word with nothing expected: sample_out %0d saturated %0b",
					out_data.sample_out, out_data.saturated);
				mismatches++;
			end else begin
				want = pending_outputs.pop_front();
				outputs_checked++;
				if (out_data.saturated) saturated_seen++;
				if (out_data.sample_out !== want.sample_out) begin
					$error("sample_out: expected %0d, got %0d", want.sample_out,
						out_data.sample_out);
					mismatches++;
				end
				if (out_data.saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b", want.saturated,
						out_data.saturated);
					mismatches++;
				end
			end
		end
	end

	// one word on the input channel; valid stays high into the next word unless a gap is drawn
	task automatic send_sample(input logic signed [iirf_pkg::SAMPLE_WIDTH-1:0] s,
		input logic pulse);
		iirf_pkg::in_word_t w;
		w.sample_in = s;
		w.pulse_start = pulse;
		if (!calm) begin
			while ($urandom_range(99) < 25) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_outputs.push_back(compute_filter_output(w));
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [iirf_pkg::CFG_IDX_W-1:0] idx,
		input logic [iirf_pkg::CFG_WIDTH-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx) inside
			iirf_pkg::REG_FEEDBACK_ONE, iirf_pkg::REG_FEEDBACK_TWO,
			iirf_pkg::REG_FORWARD_ONE, iirf_pkg::REG_FORWARD_TWO:
				cfg_shadow[idx] = v;
			iirf_pkg::REG_FORWARD_LAST: cfg_shadow[idx] = {32'd0, v[31:0]};
			default: ;
		endcase
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_filter(input iirf_pkg::coef_set_t cs);
		write_reg(iirf_pkg::REG_FEEDBACK_ONE, {cs.a[1], cs.a[0]});
		write_reg(iirf_pkg::REG_FEEDBACK_TWO, {cs.a[3], cs.a[2]});
		write_reg(iirf_pkg::REG_FORWARD_ONE, {cs.b[1], cs.b[0]});
		write_reg(iirf_pkg::REG_FORWARD_TWO, {cs.b[3], cs.b[2]});
		// upper half of the last register is don't-care
		write_reg(iirf_pkg::REG_FORWARD_LAST, {32'($urandom), cs.b[4]});
		settings_used++;
	endtask

	function automatic logic signed [iirf_pkg::SAMPLE_WIDTH-1:0] draw_sample();
		case ($urandom_range(15))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly pulses that open with pulse_start, some runs that just continue
	task automatic send_pulses(input int count);
		int run;
		while (count > 0) begin
			run = $urandom_range(4, 60);
			for (int i = 0; i < run && count > 0; i++) begin
				send_sample(draw_sample(), (i == 0) && ($urandom_range(9) != 0));
				count--;
			end
		end
	endtask

	function automatic iirf_pkg::coef_set_t stable_coefs();
		iirf_pkg::coef_set_t cs;
		// |a| <= 1/16 each keeps the loop well inside stability
		for (int i = 0; i < 4; i++)
			cs.a[i] = 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
		for (int i = 0; i < 5; i++)
			cs.b[i] = 32'($signed($urandom_range(0, 1 << 29)) - (1 << 28));
		return cs;
	endfunction

	task automatic test_reset_state();
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		drain();
	endtask

	task automatic test_passthrough_and_rounding();
		iirf_pkg::coef_set_t cs;
		cs = '0;
		cs.b[0] = COEF_ONE;
		program_filter(cs);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'shFFFF, 1'b0);
		send_sample(16'sh5555, 1'b0);
		send_sample(16'shAAAA, 1'b0);
		drain();
		// half-way values: ties go toward plus infinity
		cs.b[0] = COEF_HALF;
		program_filter(cs);
		send_sample(16'sd1, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd3, 1'b0);
		send_sample(-16'sd3, 1'b0);
		drain();
	endtask

	task automatic test_saturation_and_pulse_clear();
		iirf_pkg::coef_set_t cs;
		cs = '0;
		cs.b[0] = COEF_MAX;
		cs.a[0] = COEF_MIN;  // y = b0*x + 8*y1, runs away quickly
		program_filter(cs);
		send_sample(16'sh7FFF, 1'b1);
		for (int i = 0; i < 5; i++) send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b1);
		for (int i = 0; i < 3; i++) send_sample(16'sh8000, 1'b0);
		drain();
		// write to a nonexistent register must change nothing
		write_reg(UNUSED_REG_INDEX, '1);
		send_sample(16'sd100, 1'b1);
		send_sample(16'sd100, 1'b0);
		drain();
	endtask

	task automatic test_random_settings();
		iirf_pkg::coef_set_t cs;
		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 5) inside
				0, 2: cs = stable_coefs();
				1: cs = iirf_pkg::coef_set_t'({$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom});
				3: begin
					for (int i = 0; i < 4; i++) cs.a[i] = COEF_MAX;
					for (int i = 0; i < 5; i++) cs.b[i] = COEF_MAX;
				end
				default: begin
					for (int i = 0; i < 4; i++) cs.a[i] = COEF_MIN;
					for (int i = 0; i < 5; i++) cs.b[i] = COEF_MIN;
				end
			endcase
			program_filter(cs);
			send_pulses(150);
			drain();
		end
	endtask

	task automatic test_full_rate();
		program_filter(stable_coefs());
		calm = 1'b1;
		send_pulses(150);
		drain();
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		program_filter(stable_coefs());
		hold_requests++;
		send_pulses(100);
		// sender waits here until every word has come back
		drain();
	endtask

	initial begin
		for (int i = 0; i < 5; i++) cfg_shadow[i] = '0;
		for (int i = 0; i < 4; i++) begin
			x_hist[i] = '0;
			y_hist[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_passthrough_and_rounding();
		test_saturation_and_pulse_clear();
		test_random_settings();
		test_full_rate();
		test_backpressure();
		drain();
		repeat (8) @(posedge clk);
		$display("Ran %0d samples through %0d coefficient settings, incl. extremes and stalls.",
			words_sent, settings_used);
		$display("Checked %0d output words, %0d of them clipped; %0d mismatches.",
			outputs_checked, saturated_seen, mismatches);
		if (mismatches == 0 && pending_outputs.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: iir_fourth_order_filter_core.f
design/iirf_pkg.sv
design/iirf_coef_regs.sv
design/iirf_datapath.sv
design/iirf_hist.sv
design/iir_fourth_order_filter_core.sv
test/iir_fourth_order_filter_core_tb.sv
